FILE: design/brp_pkg.sv
// ---------------------------------------------------------------------------
// brp_pkg: shared types and constants of the buffered radix partitioner
// Field widths, register codes, controller states and the command and
// status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package brp_pkg;

   // Default sizing of the bucket and slot stores
   localparam int DEF_MAX_LOG2_BUCKETS = 8;
   localparam int DEF_SLOT_ROWS        = 16;
   localparam int DEF_PAYLOAD_BITS     = 64;

   // Stream field widths
   localparam int HASH_W     = 32;
   localparam int PAY_W      = 64;
   localparam int FLUSH_W    = 8;
   localparam int BUCKET_W   = 8;
   localparam int INDEX_W    = 32;
   localparam int REQ_DATA_W = 104;   // 13 bytes, no padding needed
   localparam int RSP_DATA_W = 104;   // 13 bytes, no padding needed

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   // Register indexes; the fourth code selects nothing
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIT_SHIFT     = 2'd0,
      CSR_LOG2_BUCKETS  = 2'd1,
      CSR_SLOT_CAPACITY = 2'd2
   } csr_index_type;

   // Register reset values
   localparam logic [4:0] RST_BIT_SHIFT     = 5'd0;
   localparam logic [3:0] RST_LOG2_BUCKETS  = 4'd8;
   localparam logic [4:0] RST_SLOT_CAPACITY = 5'd16;

   // Item operation carried in tuser
   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DECIDE,
      ST_ROW_RD,
      ST_ROW_OUT,
      ST_COMMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_wr;   // zero one count entry, step the sweep
      logic capture;    // take the accepted item, register its bucket
      logic decide;     // latch fill and emitted counts, restart row count
      logic row_emit;   // load the output register with the current row
      logic commit;     // write counts back, store the added row
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last; // sweep is at the final count entry
      logic drain;      // the bucket's rows go out as a run
      logic last_row;   // current row closes the run
      logic rsp_free;   // output register takes a row this cycle
   } status_type;

endpackage

`default_nettype wire

FILE: design/brp_ctrl.sv
// ---------------------------------------------------------------------------
// brp_ctrl: sequencing controller of the buffered radix partitioner
// Walks each item through count lookup, optional run emission and
// write-back; after reset it runs the count memory clearing sweep.
// ---------------------------------------------------------------------------
`default_nettype none

module brp_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  brp_pkg::status_type  status,
   output brp_pkg::cmd_type     cmd
);
   import brp_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = status.drain ? ST_ROW_RD : ST_COMMIT;
         end
         ST_ROW_RD: begin
            state_in = ST_ROW_OUT;
         end
         ST_ROW_OUT: begin
            if (status.rsp_free) state_in = status.last_row ? ST_COMMIT : ST_ROW_RD;
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd          = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
         end
         ST_ROW_OUT: begin
            cmd.row_emit = status.rsp_free;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/brp_datapath.sv
// ---------------------------------------------------------------------------
// brp_datapath: storage and arithmetic of the buffered radix partitioner
// Configuration registers, bucket selection, the per-bucket count memory,
// the slot store and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module brp_datapath #(
   parameter int MAX_LOG2_BUCKETS = brp_pkg::DEF_MAX_LOG2_BUCKETS,
   parameter int SLOT_ROWS        = brp_pkg::DEF_SLOT_ROWS,
   parameter int PAYLOAD_BITS     = brp_pkg::DEF_PAYLOAD_BITS
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_we,
   input  wire  [brp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [brp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire                               req_tuser,
   input  wire  [brp_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [brp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   input  brp_pkg::cmd_type                  cmd,
   output brp_pkg::status_type               status
);
   import brp_pkg::*;

   localparam int BKT_W    = MAX_LOG2_BUCKETS;
   localparam int NUM_BKT  = 2 ** BKT_W;
   localparam int FILL_W   = $clog2(SLOT_ROWS + 1);
   localparam int ROW_W    = (SLOT_ROWS > 1) ? $clog2(SLOT_ROWS) : 1;
   localparam int SLOT_DEP = 2 ** (BKT_W + ROW_W);
   localparam int CNT_W    = INDEX_W + FILL_W;
   localparam int CMP_W    = 7;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [4:0] shift_ff, shift_in;
   logic [3:0] lb_ff,    lb_in;
   logic [4:0] cap_ff,   cap_in;

   always_comb begin
      shift_in = shift_ff;
      lb_in    = lb_ff;
      cap_in   = cap_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BIT_SHIFT:     shift_in = csr_wdata;
            CSR_LOG2_BUCKETS:  lb_in    = csr_wdata[3:0];
            CSR_SLOT_CAPACITY: cap_in   = csr_wdata;
            default:           shift_in = shift_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= RST_BIT_SHIFT;
         lb_ff    <= RST_LOG2_BUCKETS;
         cap_ff   <= RST_SLOT_CAPACITY;
      end else begin
         shift_ff <= shift_in;
         lb_ff    <= lb_in;
         cap_ff   <= cap_in;
      end
   end

   // ------------------------------------------------------------------
   // Item fields and bucket selection
   // ------------------------------------------------------------------
   logic [HASH_W-1:0]  req_hash;
   logic [PAY_W-1:0]   req_payload;
   logic [FLUSH_W-1:0] req_flush;

   assign req_hash    = req_tdata[HASH_W-1:0];
   assign req_payload = req_tdata[HASH_W+PAY_W-1:HASH_W];
   assign req_flush   = req_tdata[HASH_W+PAY_W+FLUSH_W-1:HASH_W+PAY_W];

   logic [3:0]        lb_eff;
   logic [5:0]        bits_total;
   logic [5:0]        hash_sh;
   logic [HASH_W-1:0] hash_mask;
   logic [HASH_W-1:0] hash_part;
   logic [BKT_W-1:0]  add_bucket;

   // Partition bits sit just below the skipped top bits; a window that
   // runs past bit zero falls back to the low hash bits
   always_comb begin
      lb_eff     = (lb_ff > 4'(MAX_LOG2_BUCKETS)) ? 4'(MAX_LOG2_BUCKETS) : lb_ff;
      bits_total = 6'(lb_eff) + 6'(shift_ff);
      hash_sh    = (bits_total >= 6'(HASH_W)) ? 6'd0 : 6'(HASH_W) - bits_total;
      hash_mask  = ~({HASH_W{1'b1}} << lb_eff);
      hash_part  = (req_hash >> hash_sh) & hash_mask;
      add_bucket = hash_part[BKT_W-1:0];
   end

   logic                    op_ff,      op_in;
   logic [BKT_W-1:0]        bucket_ff,  bucket_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;

   always_comb begin
      op_in      = op_ff;
      bucket_in  = bucket_ff;
      payload_in = payload_ff;
      if (cmd.capture) begin
         op_in      = req_tuser;
         bucket_in  = (op_type'(req_tuser) == OP_FLUSH) ? BKT_W'(req_flush) : add_bucket;
         payload_in = req_payload[PAYLOAD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      bucket_ff  <= bucket_in;
      payload_ff <= payload_in;
   end

   // ------------------------------------------------------------------
   // Count memory: {emitted count, fill count} per bucket
   // ------------------------------------------------------------------
   logic [CNT_W-1:0] cnt_mem [NUM_BKT];
   logic [CNT_W-1:0] cnt_rd_ff;
   logic             cnt_we;
   logic [BKT_W-1:0] cnt_waddr;
   logic [CNT_W-1:0] cnt_wdata;

   logic [INDEX_W-1:0] emit_ff, emit_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [FILL_W-1:0]  k_ff,    k_in;
   logic [BKT_W-1:0]   clr_ff,  clr_in;

   always_comb begin
      cnt_we    = cmd.clear_wr || cmd.commit;
      cnt_waddr = cmd.clear_wr ? clr_ff : bucket_ff;
      if (cmd.clear_wr) begin
         cnt_wdata = '0;
      end else if (op_type'(op_ff) == OP_ADD) begin
         cnt_wdata = {emit_ff, fill_ff + FILL_W'(1)};
      end else begin
         cnt_wdata = {emit_ff, fill_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
      cnt_rd_ff <= cnt_mem[bucket_ff];
   end

   // Clearing sweep address
   assign clr_in = cmd.clear_wr ? clr_ff + BKT_W'(1) : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // ------------------------------------------------------------------
   // Drain decision
   // ------------------------------------------------------------------
   logic [FILL_W-1:0] rd_fill;
   logic [CMP_W-1:0]  cap_eff;

   always_comb begin
      rd_fill = cnt_rd_ff[FILL_W-1:0];
      if (cap_ff == 5'd0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(SLOT_ROWS)) begin
         cap_eff = CMP_W'(SLOT_ROWS);
      end else begin
         cap_eff = CMP_W'(cap_ff);
      end
   end

   // ------------------------------------------------------------------
   // Working counts of the current bucket
   // ------------------------------------------------------------------
   always_comb begin
      emit_in = emit_ff;
      fill_in = fill_ff;
      k_in    = k_ff;
      if (cmd.decide) begin
         emit_in = cnt_rd_ff[CNT_W-1:FILL_W];
         fill_in = rd_fill;
         k_in    = '0;
      end else if (cmd.row_emit) begin
         if (emit_ff != {INDEX_W{1'b1}}) emit_in = emit_ff + INDEX_W'(1);
         k_in = k_ff + FILL_W'(1);
         if (status.last_row) fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      emit_ff <= emit_in;
      fill_ff <= fill_in;
      k_ff    <= k_in;
   end

   // ------------------------------------------------------------------
   // Slot store: one row per entry, row index in the low address bits
   // ------------------------------------------------------------------
   logic [PAYLOAD_BITS-1:0] slot_mem [SLOT_DEP];
   logic [PAYLOAD_BITS-1:0] slot_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit && (op_type'(op_ff) == OP_ADD)) begin
         slot_mem[{bucket_ff, fill_ff[ROW_W-1:0]}] <= payload_ff;
      end
      slot_rd_ff <= slot_mem[{bucket_ff, k_ff[ROW_W-1:0]}];
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BUCKET_W-1:0] rsp_bucket_ff, rsp_bucket_in;
   logic [INDEX_W-1:0]  rsp_index_ff,  rsp_index_in;
   logic [PAY_W-1:0]    rsp_data_ff,   rsp_data_in;
   logic                rsp_last_ff,   rsp_last_in;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.row_emit) begin
         rsp_valid_in  = 1'b1;
         rsp_bucket_in = BUCKET_W'(bucket_ff);
         rsp_index_in  = emit_ff;
         rsp_data_in   = PAY_W'(slot_rd_ff);
         rsp_last_in   = status.last_row;
      end else if (rsp_tready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff, rsp_index_ff, rsp_bucket_ff};
   assign rsp_tlast  = rsp_last_ff;

   // ------------------------------------------------------------------
   // Status to the controller
   // ------------------------------------------------------------------
   always_comb begin
      status.clear_last = (clr_ff == {BKT_W{1'b1}});
      if (op_type'(op_ff) == OP_FLUSH) begin
         status.drain = (rd_fill != '0);
      end else begin
         status.drain = (CMP_W'(rd_fill) >= cap_eff);
      end
      status.last_row = (({1'b0, k_ff} + (FILL_W + 1)'(1)) == {1'b0, fill_ff});
      status.rsp_free = !rsp_valid_ff || rsp_tready;
   end

endmodule

`default_nettype wire

FILE: design/buffered_radix_partitioner_core.sv
// ---------------------------------------------------------------------------
// buffered_radix_partitioner_core: hash-join radix partitioner
// Sorts rows into buckets by hash bits, buffers them per bucket and emits
// each full or flushed buffer as one run tagged with bucket and output index.
// ---------------------------------------------------------------------------
// An item that emits nothing goes from acceptance through the read, decide
// and commit states back to idle; one that emits a run adds a row-read and
// a row-output state per row, waiting in row-output while the result side
// stalls. Each row of a run costs one slot-store read and one load of the
// output register, and the count memory is read and written once per item
// over its single port pair. After reset the block sweeps the count memory
// clear, all 2**MAX_LOG2_BUCKETS entries (256 by default), one bucket per
// cycle, with req_tready low; configuration writes are taken during the
// sweep. Results leave through an output register, so the next item is
// accepted while the last row of a run still waits for rsp_tready.
// ---------------------------------------------------------------------------
`default_nettype none

module buffered_radix_partitioner_core #(
   parameter int MAX_LOG2_BUCKETS = brp_pkg::DEF_MAX_LOG2_BUCKETS,
   parameter int SLOT_ROWS        = brp_pkg::DEF_SLOT_ROWS,
   parameter int PAYLOAD_BITS     = brp_pkg::DEF_PAYLOAD_BITS
) (
   input  wire                             clock,
   input  wire                             reset,
   // Configuration writes
   input  wire                             csr_we,
   input  wire  [brp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [brp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // Items in
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire  [brp_pkg::REQ_DATA_W-1:0]  req_tdata,  // hash_key, payload, flush_bucket
   input  wire                             req_tuser,  // operation
   // Rows out
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [brp_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // bucket, out_index, row_data
   output logic                            rsp_tlast   // last_of_run
);
   import brp_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer
   brp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Stores, counters and output register
   brp_datapath #(
      .MAX_LOG2_BUCKETS (MAX_LOG2_BUCKETS),
      .SLOT_ROWS        (SLOT_ROWS),
      .PAYLOAD_BITS     (PAYLOAD_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

FILE: design/brp_checker.sv
// ---------------------------------------------------------------------------
// brp_checker: port-level checks of the buffered radix partitioner
// Watches the item and row channels: output register behaviour, item
// spacing and the bucket and index sequence within a run.
// ---------------------------------------------------------------------------
`default_nettype none

module brp_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_tvalid,
   input wire                             req_tready,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [brp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire                             rsp_tlast
);
   import brp_pkg::*;

   logic                run_open_ff, run_open_in;
   logic [BUCKET_W-1:0] prev_bucket_ff, prev_bucket_in;
   logic [INDEX_W-1:0]  prev_index_ff,  prev_index_in;
   logic                rsp_xfer;
   logic                req_xfer;
   logic [BUCKET_W-1:0] rsp_bucket;
   logic [INDEX_W-1:0]  rsp_index;

   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_bucket = rsp_tdata[BUCKET_W-1:0];
   assign rsp_index  = rsp_tdata[BUCKET_W+INDEX_W-1:BUCKET_W];

   // Track the open run and its previous row
   always_comb begin
      run_open_in    = run_open_ff;
      prev_bucket_in = prev_bucket_ff;
      prev_index_in  = prev_index_ff;
      if (rsp_xfer) begin
         run_open_in    = !rsp_tlast;
         prev_bucket_in = rsp_bucket;
         prev_index_in  = rsp_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff <= 1'b0;
      end else begin
         run_open_ff <= run_open_in;
      end
      prev_bucket_ff <= prev_bucket_in;
      prev_index_ff  <= prev_index_in;
   end

   // No row is offered straight after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("row offered right after reset");

   // A stalled row holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled row changed");

   // Items are taken one at a time
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("item taken in the cycle after a transfer");

   // All rows of a run share one bucket
   a_run_bucket: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && run_open_ff |-> rsp_bucket == prev_bucket_ff)
      else $error("bucket changed within a run");

   // Output index steps by one within a run, or stays saturated
   a_run_index: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && run_open_ff |->
         (rsp_index == prev_index_ff + INDEX_W'(1)) ||
         ((prev_index_ff == {INDEX_W{1'b1}}) && (rsp_index == {INDEX_W{1'b1}})))
      else $error("output index out of sequence within a run");

endmodule

bind buffered_radix_partitioner_core brp_checker u_brp_checker (.*);

`default_nettype wire
